// ===== sv/ksf_pkg.sv =====
`timescale 1ns / 1ps
package ksf_pkg;

  localparam int MAX_ENTRIES_DEF  = 32;
  localparam int MAX_WORD_LEN_DEF = 64;

  localparam logic [2:0] MODE_TEXT    = 3'd0;
  localparam logic [2:0] MODE_ADD     = 3'd1;
  localparam logic [2:0] MODE_LIST    = 3'd2;
  localparam logic [2:0] MODE_REMOVE  = 3'd3;
  localparam logic [2:0] MODE_CLEAR   = 3'd4;
  localparam logic [2:0] MODE_INIT    = 3'd5;
  localparam logic [2:0] MODE_CLEANUP = 3'd6;
  localparam logic [2:0] MODE_NOP     = 3'd7;

  localparam logic [7:0] LIST_SEP = 8'h2C;

  localparam int NUM_DEF  = 4;
  localparam int DEF_SPAN = 22;

  localparam logic [7:0] DEF_BYTES [NUM_DEF][DEF_SPAN] = '{
    '{8'hD0, 8'hBC, 8'hD0, 8'hB0, 8'hD1, 8'h82, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hD1, 8'h81, 8'hD0, 8'hBF, 8'hD0, 8'hB0, 8'hD0, 8'hBC, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hD0, 8'hBE, 8'hD1, 8'h81, 8'hD0, 8'hBA, 8'hD0, 8'hBE, 8'hD1, 8'h80, 8'hD0,
      8'hB1, 8'hD0, 8'hBB, 8'hD0, 8'hB5, 8'hD0, 8'hBD, 8'hD0, 8'hB8, 8'hD0, 8'hB5},
    '{8'hD0, 8'hBD, 8'hD0, 8'hB5, 8'hD0, 8'hBD, 8'hD0, 8'hB0, 8'hD0, 8'hB2, 8'hD0,
      8'hB8, 8'hD1, 8'h81, 8'hD1, 8'h82, 8'hD1, 8'h8C, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [6:0] DEF_LEN [NUM_DEF] = '{7'd6, 7'd8, 7'd22, 7'd18};

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_data_t;

  typedef struct packed {
    logic       matched;
    logic [4:0] match_index;
    logic [6:0] match_length;
    logic [5:0] entry_total;
    logic       table_full;
    logic       word_too_long;
  } out_data_t;

endpackage

// ===== sv/keyword_substring_filter.sv =====
`timescale 1ns / 1ps
// channel  direction  handshake            payload
// in_      input      in_valid / in_stall  in_data   (in_data_t)
// out_     output     out_valid / out_stall out_data (out_data_t)
//
// Word and list bytes other than the last are taken without stalling. A text
// byte runs one pass over the table, one entry per cycle, and holds in_stall
// for the pass, the last byte also to emit. Add runs a duplicate pass and a
// push if absent, remove a compacting pass, a list end a push; clear, cleanup
// and a default load emit a result. Reset (rst_n low, synchronous) clears control
// state, not the table memories; emit repeats while out_stall holds a result.
module keyword_substring_filter
  import ksf_pkg::*;
#(
  parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
  parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_data_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_data_t out_data
);

  localparam int MW  = MAX_WORD_LEN;
  localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int WLW = $clog2(MAX_WORD_LEN + 1);
  localparam int BW  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int RW  = WLW + MW * 8;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIN  = 3'd1;
  localparam logic [2:0] S_PASS = 3'd2;
  localparam logic [2:0] S_PUSH = 3'd3;
  localparam logic [2:0] S_DEF  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  localparam logic [1:0] K_TEXT = 2'd0;
  localparam logic [1:0] K_DUP  = 2'd1;
  localparam logic [1:0] K_REM  = 2'd2;

  function automatic logic [7:0] fold(input logic [7:0] b);
    if (b >= 8'h41 && b <= 8'h5A) begin
      return b + 8'h20;
    end
    return b;
  endfunction

  logic [RW-1:0] pat_mem [MAX_ENTRIES];
  logic [MW-1:0] prog_mem [MAX_ENTRIES];

  logic [2:0]             state_r, state_nxt;
  logic [1:0]             kind_r, kind_nxt;
  logic [2:0]             mode_r, mode_nxt;
  logic [7:0]             c_r, c_nxt;
  logic                   has_r, has_nxt;
  logic                   last_r, last_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   ready_r, ready_nxt;
  logic                   seq_open_r, seq_open_nxt;
  logic [2:0]             seq_mode_r, seq_mode_nxt;
  logic                   sf_r, sf_nxt;
  logic                   sl_r, sl_nxt;
  logic [WLW-1:0]         wl_r, wl_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [MW*8-1:0]        wbuf_r, wbuf_nxt;
  logic [MAX_ENTRIES-1:0] prog_vld_r, prog_vld_nxt;
  logic [MAX_ENTRIES-1:0] hit_r, hit_nxt;
  logic [CW-1:0]          rd_idx_r, rd_idx_nxt;
  logic                   p_vld_r, p_vld_nxt;
  logic [AW-1:0]          p_idx_r, p_idx_nxt;
  logic [CW-1:0]          dst_r, dst_nxt;
  logic                   found_r, found_nxt;
  logic [AW-1:0]          fidx_r, fidx_nxt;
  logic [WLW-1:0]         flen_r, flen_nxt;
  logic                   present_r, present_nxt;
  logic [1:0]             def_k_r, def_k_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_data_t              out_r, out_nxt;
  logic [RW-1:0]          pat_rd_r;
  logic [MW-1:0]          prog_rd_r;

  logic          rd_en;
  logic          pat_we;
  logic [AW-1:0] pat_waddr;
  logic [RW-1:0] pat_wrow;
  logic          prog_we;

  logic [WLW-1:0]  row_len;
  logic [MW*8-1:0] row_bytes;
  logic [MW-1:0]   pv, eq, vec;
  logic [MW-1:0]   word_byte_ok;
  logic            word_eq;
  logic            hit_new;
  logic [MW*8-1:0] def_row;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign rd_en     = (state_r == S_PASS) && (rd_idx_r < count_r);
  assign row_len   = pat_rd_r[RW-1 -: WLW];
  assign row_bytes = pat_rd_r[MW*8-1:0];
  assign pv        = prog_vld_r[p_idx_r] ? prog_rd_r : '0;

  always_comb begin
    for (int i = 0; i < MW; i++) begin
      eq[i] = (WLW'(i) < row_len) && (row_bytes[i*8 +: 8] == c_r);
      word_byte_ok[i] = (WLW'(i) >= row_len) || (row_bytes[i*8 +: 8] == wbuf_r[i*8 +: 8]);
    end
  end

  assign vec     = ((pv << 1) | MW'(1)) & eq;
  assign word_eq = (row_len == wl_r) && (&word_byte_ok);
  assign hit_new = hit_r[p_idx_r] |
                   (has_r && (row_len != '0) && vec[BW'(row_len - WLW'(1))]);

  always_comb begin
    def_row = '0;
    for (int i = 0; i < MW; i++) begin
      if (i < DEF_SPAN) begin
        def_row[i*8 +: 8] = DEF_BYTES[def_k_r][i];
      end
    end
  end

  always_comb begin
    logic           in_acc;
    logic           newseq;
    logic [WLW-1:0] wl_b;
    logic           ovf_b;
    logic [7:0]     cf;
    logic           m;

    in_acc = in_valid && !in_stall;
    cf     = fold(in_data.data_byte);
    newseq = !seq_open_r || (seq_mode_r != in_data.mode);
    wl_b   = newseq ? '0 : wl_r;
    ovf_b  = newseq ? 1'b0 : ovf_r;
    m      = (mode_r == MODE_TEXT) && found_r && ready_r;

    state_nxt     = state_r;
    kind_nxt      = kind_r;
    mode_nxt      = mode_r;
    c_nxt         = c_r;
    has_nxt       = has_r;
    last_nxt      = last_r;
    count_nxt     = count_r;
    ready_nxt     = ready_r;
    seq_open_nxt  = seq_open_r;
    seq_mode_nxt  = seq_mode_r;
    sf_nxt        = sf_r;
    sl_nxt        = sl_r;
    wl_nxt        = wl_r;
    ovf_nxt       = ovf_r;
    wbuf_nxt      = wbuf_r;
    prog_vld_nxt  = prog_vld_r;
    hit_nxt       = hit_r;
    rd_idx_nxt    = rd_idx_r;
    p_vld_nxt     = 1'b0;
    p_idx_nxt     = p_idx_r;
    dst_nxt       = dst_r;
    found_nxt     = found_r;
    fidx_nxt      = fidx_r;
    flen_nxt      = flen_r;
    present_nxt   = present_r;
    def_k_nxt     = def_k_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    pat_we    = 1'b0;
    pat_waddr = count_r[AW-1:0];
    pat_wrow  = {wl_r, wbuf_r};
    prog_we   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt = in_data.mode;
          c_nxt    = cf;
          has_nxt  = in_data.has_byte;
          last_nxt = in_data.last;
          if (in_data.mode == MODE_CLEAR || in_data.mode == MODE_INIT ||
              in_data.mode == MODE_CLEANUP) begin
            prog_vld_nxt = '0;
            hit_nxt      = '0;
            wl_nxt       = '0;
            ovf_nxt      = 1'b0;
            sf_nxt       = 1'b0;
            sl_nxt       = 1'b0;
            seq_open_nxt = 1'b0;
            state_nxt    = S_EMIT;
            if (in_data.mode == MODE_CLEAR) begin
              count_nxt = '0;
            end else if (in_data.mode == MODE_CLEANUP) begin
              count_nxt = '0;
              ready_nxt = 1'b0;
            end else if (!ready_r) begin
              ready_nxt = 1'b1;
              def_k_nxt = '0;
              state_nxt = S_DEF;
            end
          end else if (in_data.mode != MODE_NOP) begin
            // drop whatever sequence was open under another mode
            if (newseq) begin
              prog_vld_nxt = '0;
              hit_nxt      = '0;
              sf_nxt       = 1'b0;
              sl_nxt       = 1'b0;
            end
            wl_nxt       = wl_b;
            ovf_nxt      = ovf_b;
            seq_open_nxt = 1'b1;
            seq_mode_nxt = in_data.mode;
            if (in_data.has_byte && in_data.mode != MODE_TEXT) begin
              if (in_data.mode == MODE_LIST && cf == LIST_SEP) begin
                if (ovf_b) begin
                  sl_nxt = 1'b1;
                end else if (wl_b != '0) begin
                  if (count_r >= CW'(MAX_ENTRIES)) begin
                    sf_nxt = 1'b1;
                  end else begin
                    pat_we    = 1'b1;
                    pat_wrow  = {wl_b, wbuf_r};
                    count_nxt = count_r + CW'(1);
                  end
                end
                wl_nxt  = '0;
                ovf_nxt = 1'b0;
              end else if (wl_b < WLW'(MW)) begin
                wbuf_nxt[8*wl_b +: 8] = cf;
                wl_nxt = wl_b + WLW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            if (in_data.mode == MODE_TEXT) begin
              if (in_data.has_byte || in_data.last) begin
                kind_nxt   = K_TEXT;
                rd_idx_nxt = '0;
                found_nxt  = 1'b0;
                state_nxt  = S_PASS;
              end
            end else if (in_data.last) begin
              state_nxt = S_FIN;
            end
          end
        end
      end
      S_FIN: begin
        rd_idx_nxt  = '0;
        present_nxt = 1'b0;
        dst_nxt     = '0;
        state_nxt   = S_EMIT;
        if (mode_r == MODE_LIST) begin
          state_nxt = S_PUSH;
        end else if (ovf_r) begin
          sl_nxt = 1'b1;
        end else if (mode_r == MODE_ADD) begin
          kind_nxt  = K_DUP;
          state_nxt = S_PASS;
        end else begin
          kind_nxt  = K_REM;
          state_nxt = S_PASS;
        end
      end
      S_PUSH: begin
        if (ovf_r) begin
          sl_nxt = 1'b1;
        end else if (!(mode_r == MODE_LIST && wl_r == '0)) begin
          if (count_r >= CW'(MAX_ENTRIES)) begin
            sf_nxt = 1'b1;
          end else begin
            pat_we    = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        state_nxt = S_EMIT;
      end
      S_PASS: begin
        if (rd_en) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
        end
        p_vld_nxt = rd_en;
        p_idx_nxt = rd_idx_r[AW-1:0];
        if (p_vld_r) begin
          unique case (kind_r)
            K_TEXT: begin
              if (has_r && row_len != '0) begin
                prog_we                = 1'b1;
                prog_vld_nxt[p_idx_r] = 1'b1;
                hit_nxt[p_idx_r]      = hit_new;
              end
              if (last_r && !found_r && (row_len == '0 || hit_new)) begin
                found_nxt = 1'b1;
                fidx_nxt  = p_idx_r;
                flen_nxt  = row_len;
              end
            end
            K_DUP: begin
              if (word_eq) begin
                present_nxt = 1'b1;
              end
            end
            K_REM: begin
              // close up: surviving entries move down to the write pointer
              if (!word_eq) begin
                if (dst_r[AW-1:0] != p_idx_r) begin
                  pat_we    = 1'b1;
                  pat_waddr = dst_r[AW-1:0];
                  pat_wrow  = pat_rd_r;
                end
                dst_nxt = dst_r + CW'(1);
              end
            end
            default: begin
            end
          endcase
        end
        if (!rd_en && !p_vld_r) begin
          unique case (kind_r)
            K_TEXT:  state_nxt = last_r ? S_EMIT : S_IDLE;
            K_DUP:   state_nxt = present_r ? S_EMIT : S_PUSH;
            K_REM: begin
              count_nxt = dst_r;
              state_nxt = S_EMIT;
            end
            default: state_nxt = S_EMIT;
          endcase
        end
      end
      S_DEF: begin
        if (int'(DEF_LEN[def_k_r]) > MAX_WORD_LEN) begin
          sl_nxt = 1'b1;
        end else if (count_r >= CW'(MAX_ENTRIES)) begin
          sf_nxt = 1'b1;
        end else begin
          pat_we    = 1'b1;
          pat_wrow  = {WLW'(DEF_LEN[def_k_r]), def_row};
          count_nxt = count_r + CW'(1);
        end
        def_k_nxt = def_k_r + 2'd1;
        if (def_k_r == 2'(NUM_DEF - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_nxt.matched       = m;
          out_nxt.match_index   = m ? 5'(fidx_r) : 5'd0;
          out_nxt.match_length  = m ? 7'(flen_r) : 7'd0;
          out_nxt.entry_total   = 6'(count_r);
          out_nxt.table_full    = sf_r;
          out_nxt.word_too_long = sl_r;
          prog_vld_nxt          = '0;
          hit_nxt               = '0;
          wl_nxt                = '0;
          ovf_nxt               = 1'b0;
          sf_nxt                = 1'b0;
          sl_nxt                = 1'b0;
          seq_open_nxt          = 1'b0;
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[pat_waddr] <= pat_wrow;
    end
    if (rd_en) begin
      pat_rd_r <= pat_mem[rd_idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (prog_we) begin
      prog_mem[p_idx_r] <= vec;
    end
    if (rd_en) begin
      prog_rd_r <= prog_mem[rd_idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ready_r     <= 1'b0;
      seq_open_r  <= 1'b0;
      seq_mode_r  <= MODE_TEXT;
      sf_r        <= 1'b0;
      sl_r        <= 1'b0;
      wl_r        <= '0;
      ovf_r       <= 1'b0;
      prog_vld_r  <= '0;
      hit_r       <= '0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ready_r     <= ready_nxt;
      seq_open_r  <= seq_open_nxt;
      seq_mode_r  <= seq_mode_nxt;
      sf_r        <= sf_nxt;
      sl_r        <= sl_nxt;
      wl_r        <= wl_nxt;
      ovf_r       <= ovf_nxt;
      prog_vld_r  <= prog_vld_nxt;
      hit_r       <= hit_nxt;
      p_vld_r     <= p_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    mode_r    <= mode_nxt;
    c_r       <= c_nxt;
    has_r     <= has_nxt;
    last_r    <= last_nxt;
    wbuf_r    <= wbuf_nxt;
    rd_idx_r  <= rd_idx_nxt;
    p_idx_r   <= p_idx_nxt;
    dst_r     <= dst_nxt;
    found_r   <= found_nxt;
    fidx_r    <= fidx_nxt;
    flen_r    <= flen_nxt;
    present_r <= present_nxt;
    def_k_r   <= def_k_nxt;
    out_r     <= out_nxt;
  end

endmodule

// ===== sv/ksf_checker.sv =====
`timescale 1ns / 1ps
module ksf_props
  import ksf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_data_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_data_t out_data
);

  // hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // results are produced only while input is held off
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without busy phase");

  // a clear always produces a result, so the block goes busy
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.mode == MODE_CLEAR |=> in_stall)
    else $error("clear not taken up");

endmodule

bind keyword_substring_filter ksf_props u_ksf_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== dv/ksf_checker.sv =====
`timescale 1ns / 1ps
module ksf_checker
  import ksf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_data_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_data_t out_data,
  output int        fail_count,
  output int        pending
);

  localparam int NE = MAX_ENTRIES_DEF;
  localparam int NW = MAX_WORD_LEN_DEF;

  logic [7:0]  kw_bytes [NE][NW];
  logic [6:0]  kw_len [NE];
  int          kw_count;
  logic        armed;
  logic [63:0] prog [NE];
  logic        hit [NE];
  logic [7:0]  wbuf [NW];
  int          wlen;
  logic        wover;
  logic        open_seq;
  logic [2:0]  open_mode;
  logic        full_seen;
  logic        long_seen;

  out_data_t   expected_results [$];

  function automatic logic [7:0] lower(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
  endfunction

  task automatic reset_seq();
    for (int e = 0; e < NE; e++) begin
      prog[e] = '0;
      hit[e] = 1'b0;
    end
    wlen = 0;
    wover = 1'b0;
    full_seen = 1'b0;
    long_seen = 1'b0;
    open_seq = 1'b0;
    open_mode = MODE_TEXT;
  endtask

  task automatic push_kw(int len, logic [7:0] w [NW]);
    if (kw_count >= NE) begin
      full_seen = 1'b1;
      return;
    end
    for (int i = 0; i < len; i++) kw_bytes[kw_count][i] = w[i];
    kw_len[kw_count] = len[6:0];
    prog[kw_count] = '0;
    hit[kw_count] = 1'b0;
    kw_count++;
  endtask

  function automatic logic same_kw(int e);
    if (kw_len[e] != wlen) return 1'b0;
    for (int i = 0; i < wlen; i++)
      if (kw_bytes[e][i] != wbuf[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic commit_word(logic dedup, logic skip_empty);
    logic present;
    present = 1'b0;
    if (wover) long_seen = 1'b1;
    else if (!(skip_empty && wlen == 0)) begin
      if (dedup)
        for (int e = 0; e < kw_count; e++) if (same_kw(e)) present = 1'b1;
      if (!present) push_kw(wlen, wbuf);
    end
    wlen = 0;
    wover = 1'b0;
  endtask

  task automatic drop_word();
    int dst;
    dst = 0;
    if (wover) begin
      long_seen = 1'b1;
      return;
    end
    for (int s = 0; s < kw_count; s++) begin
      if (same_kw(s)) continue;
      if (dst != s) begin
        kw_bytes[dst] = kw_bytes[s];
        kw_len[dst] = kw_len[s];
        prog[dst] = '0;
        hit[dst] = 1'b0;
      end
      dst++;
    end
    kw_count = dst;
  endtask

  task automatic scan_byte(logic [7:0] c);
    logic [63:0] eq;
    int len;
    for (int e = 0; e < kw_count; e++) begin
      len = kw_len[e];
      if (len == 0 || len > NW) continue;
      eq = '0;
      for (int i = 0; i < len; i++) if (kw_bytes[e][i] == c) eq[i] = 1'b1;
      prog[e] = ((prog[e] << 1) | 64'd1) & eq;
      if (prog[e][len-1]) hit[e] = 1'b1;
    end
  endtask

  task automatic predict(in_data_t t);
    out_data_t r;
    logic [7:0] c;
    logic [7:0] w [NW];
    c = lower(t.data_byte);
    r = '0;
    if (t.mode == MODE_NOP) return;
    if (t.mode >= MODE_CLEAR) begin
      reset_seq();
      if (t.mode == MODE_CLEAR) kw_count = 0;
      else if (t.mode == MODE_CLEANUP) begin
        kw_count = 0;
        armed = 1'b0;
      end else if (!armed) begin
        for (int k = 0; k < NUM_DEF; k++) begin
          for (int i = 0; i < NW; i++) w[i] = (i < DEF_SPAN) ? DEF_BYTES[k][i] : 8'h00;
          push_kw(DEF_LEN[k], w);
        end
        armed = 1'b1;
      end
      r.entry_total = kw_count[5:0];
      r.table_full = full_seen;
      r.word_too_long = long_seen;
      expected_results = {expected_results, r};
      reset_seq();
      return;
    end
    if (!open_seq || open_mode != t.mode) reset_seq();
    open_seq = 1'b1;
    open_mode = t.mode;
    if (t.has_byte) begin
      if (t.mode == MODE_TEXT) scan_byte(c);
      else if (t.mode == MODE_LIST && c == LIST_SEP) commit_word(1'b0, 1'b1);
      else if (wlen < NW) begin
        wbuf[wlen] = c;
        wlen++;
      end
      else wover = 1'b1;
    end
    if (!t.last) return;
    if (t.mode == MODE_TEXT) begin
      if (armed)
        for (int e = 0; e < kw_count; e++)
          if (kw_len[e] == 0 || hit[e]) begin
            r.matched = 1'b1;
            r.match_index = e[4:0];
            r.match_length = kw_len[e];
            break;
          end
    end else if (t.mode == MODE_ADD) commit_word(1'b1, 1'b0);
    else if (t.mode == MODE_LIST) commit_word(1'b0, 1'b1);
    else drop_word();
    r.entry_total = kw_count[5:0];
    r.table_full = full_seen;
    r.word_too_long = long_seen;
    expected_results = {expected_results, r};
    reset_seq();
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_data_t x;
    if (!rst_n) begin
      kw_count = 0;
      armed = 1'b0;
      reset_seq();
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) report("unexpected transaction", 1, 0);
        else begin
          x = expected_results.pop_front();
          if (out_data.matched != x.matched)
            report("matched", out_data.matched, x.matched);
          if (out_data.match_index != x.match_index)
            report("match_index", out_data.match_index, x.match_index);
          if (out_data.match_length != x.match_length)
            report("match_length", out_data.match_length, x.match_length);
          if (out_data.entry_total != x.entry_total)
            report("entry_total", out_data.entry_total, x.entry_total);
          if (out_data.table_full != x.table_full)
            report("table_full", out_data.table_full, x.table_full);
          if (out_data.word_too_long != x.word_too_long)
            report("word_too_long", out_data.word_too_long, x.word_too_long);
        end
      end
      if (in_valid && !in_stall) predict(in_data);
    end
    pending = expected_results.size();
  end

endmodule

// ===== dv/tb_keyword_substring_filter.sv =====
`timescale 1ns / 1ps
module tb_keyword_substring_filter;
  import ksf_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_data_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_data_t out_data;
  int        fail_count;
  int        pending;
  logic      hold_off;

  keyword_substring_filter i_dut (.*);

  ksf_checker i_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("FAIL");
    $finish;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_stall <= 1'b1;
      else out_stall <= (gap_len() > 0) && ($urandom_range(0, 2) == 0);
    end
  end

  int calm;

  // Leave valid up after acceptance; a gap in the next call or the end of stimulus drops it.
  task automatic send(logic [2:0] m, logic [7:0] b, logic hb, logic lst);
    int g;
    g = (calm > 0) ? 0 : gap_len();
    repeat (g) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{mode: m, data_byte: b, has_byte: hb, last: lst};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_str(logic [2:0] m, string s);
    if (s.len() == 0) send(m, 8'h00, 1'b0, 1'b1);
    for (int i = 0; i < s.len(); i++) send(m, s[i], 1'b1, i == s.len() - 1);
  endtask

  task automatic send_rand(logic [2:0] m, int n, int span);
    for (int i = 0; i < n; i++)
      send(m, span == 0 ? 8'($urandom_range(0, 255)) : 8'(8'h61 + $urandom_range(0, span)),
           1'b1, i == n - 1);
    if (n == 0) send(m, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  initial begin
    int p;
    int n;
    hold_off = 1'b0;
    calm = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Directed part.
    send_str(MODE_TEXT, "matxyz");
    send(MODE_INIT, 8'h00, 1'b0, 1'b0);
    send(MODE_INIT, 8'hFF, 1'b1, 1'b1);
    send_str(MODE_ADD, "AbC");
    send_str(MODE_ADD, "abc");
    send_str(MODE_TEXT, "xxABCx");
    send(MODE_ADD, 8'h00, 1'b0, 1'b1);
    send_str(MODE_TEXT, "");
    send_str(MODE_REMOVE, "");
    send(MODE_LIST, 8'h7A, 1'b1, 1'b0);
    send(MODE_LIST, 8'h00, 1'b1, 1'b0);
    send(MODE_LIST, 8'h00, 1'b0, 1'b0);
    send_str(MODE_LIST, ",,q,");
    send_rand(MODE_ADD, 70, 0);
    send(MODE_NOP, 8'h55, 1'b1, 1'b1);
    send(MODE_TEXT, 8'h61, 1'b1, 1'b0);
    send_str(MODE_REMOVE, "q");
    send(MODE_CLEAR, 8'h00, 1'b0, 1'b0);
    send(MODE_CLEANUP, 8'h00, 1'b0, 1'b0);
    // Random part, mostly well-formed operations with small alphabets.
    for (int k = 0; k < 250; k++) begin
      p = $urandom_range(0, 99);
      n = $urandom_range(0, 5);
      if (k == 200) begin
        // Hold the receiver while the sender keeps pushing transactions.
        hold_off = 1'b1;
        calm = 1;
        fork
          begin repeat (300) @(negedge clk); hold_off = 1'b0; end
        join_none
      end
      if (k == 206) calm = 0;
      if (p < 35) send_rand(MODE_TEXT, $urandom_range(0, 12), 3);
      else if (p < 40) send_rand(MODE_TEXT, $urandom_range(1, 6), 0);
      else if (p < 55) send_rand(MODE_ADD, n, 3);
      else if (p < 62) begin
        for (int i = 0; i < 8; i++)
          send(MODE_LIST,
               ($urandom_range(0, 2) == 0) ? LIST_SEP : 8'(8'h61 + $urandom_range(0, 3)),
               $urandom_range(0, 7) != 0, i == 7);
      end else if (p < 70) send_rand(MODE_REMOVE, n, 3);
      else if (p < 72) send_rand(MODE_ADD, 65 + $urandom_range(0, 2), 1);
      else if (p < 74) send_rand(MODE_REMOVE, 65, 1);
      else if (p < 78) send(MODE_INIT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
      else if (p < 80) send(MODE_CLEAR, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
      else if (p < 82) send(MODE_CLEANUP, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
      else if (p < 84) send(MODE_NOP, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
      else if (p < 88) send(3'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else if (p < 92) begin
        // Fill the table toward its limit.
        for (int i = 0; i < 12; i++) send_rand(MODE_LIST, 3, 25);
      end else send_rand(MODE_TEXT, $urandom_range(2, 8), 25);
    end
    in_valid <= 1'b0;
    while (pending > 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
